// File: rtl/first_fit_pool_allocator_core_assert.svh
// Assertion macros for the pool allocator core.
// Included by the top level; depends on nothing else.
`ifndef FIRST_FIT_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_POOL_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define FFPA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define FFPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ffpa_pkg.sv
// Shared types and constants of the pool allocator core.
// No dependencies.
package ffpa_pkg;

  localparam int FIELD_W = 12;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_EXEC  = 9'b000000100,
    S_WALK  = 9'b000001000,
    S_CHECK = 9'b000010000,
    S_CARVE = 9'b000100000,
    S_SPLIT = 9'b001000000,
    S_FIX   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

endpackage

// File: rtl/ffpa_hdr_mem.sv
// Block header store: link and size memories, one write port each,
// shared registered read port. No package dependencies.
module ffpa_hdr_mem #(
  parameter int DEPTH = 4096,
  parameter int IW    = 12,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          link_we,
  input  logic [IW-1:0] link_waddr,
  input  logic [AW-1:0] link_wdata,
  input  logic          size_we,
  input  logic [IW-1:0] size_waddr,
  input  logic [AW-1:0] size_wdata,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output logic [AW-1:0] rd_link,
  output logic [AW-1:0] rd_size
);

  logic [AW-1:0] link_mem [DEPTH];
  logic [AW-1:0] size_mem [DEPTH];

  // Write link entries
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
  end

  // Write size entries
  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[size_waddr] <= size_wdata;
    end
  end

  // Read both fields of one header
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_link <= link_mem[rd_addr];
      rd_size <= size_mem[rd_addr];
    end
  end

endmodule

// File: rtl/first_fit_pool_allocator_core.sv
// First-fit allocator over a fixed arena with a singly linked free list.
// Channels: input request (opcode, request_size, free_address) with
// in_valid/in_ready; result (block_address, status) with out_valid/out_ready;
// the growth register is written through cfg_we/cfg_wdata, which also
// re-initializes the pool; the user must do so only while idle, as the block
// itself does not enforce it. One request is in work at a time. A free goes
// from EXEC to DONE, as does an oversized allocate. A list allocate walks the
// list (WALK reads a header, CHECK compares its size) and on a fit passes
// through SPLIT and FIX to DONE; when nothing fits, CARVE cuts a block from
// the growth region and goes on through SPLIT and FIX, or fails to DONE.
// Each visit is one header read and one compare; list length sets the rate.
// A new request is accepted while the previous result waits in the output
// register; if the receiver stalls, the finished result holds in the DONE
// state until the output register frees.
// Reset: the INIT state writes the initial header, then in_ready rises.
// Depends on ffpa_pkg, ffpa_hdr_mem and the assertion macro header.
module first_fit_pool_allocator_core #(
  parameter int ARENA_BYTES     = 4096,
  parameter int HEADER_BYTES    = 16,
  parameter int MIN_BLOCK_BYTES = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         opcode,
  input  logic [ffpa_pkg::FIELD_W-1:0] request_size,
  input  logic [ffpa_pkg::FIELD_W-1:0] free_address,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ffpa_pkg::FIELD_W-1:0] block_address,
  output logic                         status,
  input  logic                         cfg_we,
  input  logic [ffpa_pkg::FIELD_W-1:0] cfg_wdata
);

  import ffpa_pkg::*;

  `include "first_fit_pool_allocator_core_assert.svh"

  localparam int IW         = $clog2(ARENA_BYTES);
  localparam int AW         = IW + 1;
  localparam int CW         = ((AW > FIELD_W) ? AW : FIELD_W) + 2;
  localparam int WALK_LIMIT = ARENA_BYTES / (HEADER_BYTES + MIN_BLOCK_BYTES) + 1;
  localparam int SW         = $clog2(WALK_LIMIT + 1);

  localparam logic [AW-1:0] NO_BLOCK   = AW'(ARENA_BYTES);
  localparam logic [CW-1:0] ARENA_C    = CW'(ARENA_BYTES);
  localparam logic [CW-1:0] HDR_C      = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] MIN_C      = CW'(MIN_BLOCK_BYTES);
  localparam logic [CW-1:0] MAX_GROW_C = CW'(ARENA_BYTES - HEADER_BYTES);
  localparam logic [FIELD_W-1:0] GROWTH_RESET = FIELD_W'(256);

  function automatic logic [AW-1:0] clamp_growth(input logic [FIELD_W-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    if (w < MIN_C) w = MIN_C;
    if (w > MAX_GROW_C) w = MAX_GROW_C;
    return AW'(w);
  endfunction

  state_t state;

  logic [AW-1:0]      growth;
  logic [AW-1:0]      head;
  logic [AW-1:0]      tail;
  logic               op;
  logic [CW-1:0]      need;
  logic [FIELD_W-1:0] free_addr;
  logic [AW-1:0]      cur;
  logic [AW-1:0]      prev;
  logic [AW-1:0]      lc;
  logic [CW-1:0]      s;
  logic [SW-1:0]      steps;
  logic               split;
  logic [FIELD_W-1:0] res_addr;
  logic               res_status;

  logic          link_we, size_we, rd_en;
  logic [IW-1:0] link_waddr, size_waddr, rd_addr;
  logic [AW-1:0] link_wdata, size_wdata, rd_link, rd_size;

  logic [AW-1:0] cfg_growth;
  logic [CW-1:0] free_h, big_end, grow_end, rest_at, res_cur;
  logic          free_ok, big_fits, grow_fits, split_ok, walk_more;
  logic [AW-1:0] repl;
  logic          out_load;

  // Derived arithmetic
  assign cfg_growth = clamp_growth(cfg_wdata);
  assign free_h     = CW'(free_addr) - HDR_C;
  assign free_ok    = (CW'(free_addr) >= HDR_C) && (free_h < ARENA_C);
  assign big_end    = CW'(tail) + HDR_C + need;
  assign big_fits   = big_end <= ARENA_C;
  assign grow_end   = CW'(tail) + HDR_C + CW'(growth);
  assign grow_fits  = grow_end <= ARENA_C;
  assign rest_at    = CW'(cur) + HDR_C + need;
  assign split_ok   = !((s < need + HDR_C + MIN_C) || (rest_at >= ARENA_C));
  assign repl       = split ? AW'(rest_at) : lc;
  assign walk_more  = (cur < NO_BLOCK) && (steps < SW'(WALK_LIMIT));
  assign res_cur    = CW'(cur) + HDR_C;
  assign out_load   = (state == S_DONE) && (!out_valid || out_ready);

  assign in_ready = (state == S_IDLE);
  assign rd_en    = (state == S_WALK) && walk_more;
  assign rd_addr  = cur[IW-1:0];

  // Header memory write ports
  always_comb begin
    link_we    = 1'b0;
    link_waddr = '0;
    link_wdata = NO_BLOCK;
    size_we    = 1'b0;
    size_waddr = '0;
    size_wdata = growth;
    if (cfg_we) begin
      link_we    = 1'b1;
      size_we    = 1'b1;
      size_wdata = cfg_growth;
    end else begin
      unique case (state)
        S_INIT: begin
          link_we = 1'b1;
          size_we = 1'b1;
        end
        S_EXEC: begin
          if (op == OP_FREE) begin
            link_we    = free_ok;
            link_waddr = free_h[IW-1:0];
            link_wdata = head;
          end else if (need > CW'(growth)) begin
            link_we    = big_fits;
            link_waddr = tail[IW-1:0];
            size_we    = big_fits;
            size_waddr = tail[IW-1:0];
            size_wdata = AW'(need);
          end
        end
        S_CARVE: begin
          link_we    = grow_fits;
          link_waddr = tail[IW-1:0];
          size_we    = grow_fits;
          size_waddr = tail[IW-1:0];
        end
        S_SPLIT: begin
          link_we    = split_ok;
          link_waddr = rest_at[IW-1:0];
          link_wdata = lc;
          size_we    = split_ok;
          size_waddr = rest_at[IW-1:0];
          size_wdata = AW'(s - need - HDR_C);
        end
        S_FIX: begin
          size_we    = split;
          size_waddr = cur[IW-1:0];
          size_wdata = AW'(need);
          link_we    = (prev != NO_BLOCK);
          link_waddr = prev[IW-1:0];
          link_wdata = repl;
        end
        default: begin
        end
      endcase
    end
  end

  ffpa_hdr_mem #(
    .DEPTH (ARENA_BYTES),
    .IW    (IW),
    .AW    (AW)
  ) u_hdr_mem (
    .clk        (clk),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .size_we    (size_we),
    .size_waddr (size_waddr),
    .size_wdata (size_wdata),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_link    (rd_link),
    .rd_size    (rd_size)
  );

  // Sequencer, pool registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
      growth    <= clamp_growth(GROWTH_RESET);
      head      <= '0;
      tail      <= AW'(HDR_C + CW'(clamp_growth(GROWTH_RESET)));
    end else begin
      // load a finished result, drop one that the receiver takes
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op        <= opcode;
            free_addr <= free_address;
            need      <= (CW'(request_size) < MIN_C) ? MIN_C : CW'(request_size);
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_addr   <= '0;
          res_status <= 1'b0;
          if (op == OP_FREE) begin
            if (free_ok) head <= AW'(free_h);
            state <= S_DONE;
          end else if (need > CW'(growth)) begin
            if (big_fits) begin
              tail     <= AW'(big_end);
              res_addr <= FIELD_W'(CW'(tail) + HDR_C);
            end else begin
              res_status <= 1'b1;
            end
            state <= S_DONE;
          end else begin
            cur   <= head;
            prev  <= NO_BLOCK;
            steps <= '0;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          state <= walk_more ? S_CHECK : S_CARVE;
        end
        S_CHECK: begin
          if (CW'(rd_size) >= need) begin
            s     <= CW'(rd_size);
            lc    <= rd_link;
            state <= S_SPLIT;
          end else begin
            prev  <= cur;
            cur   <= rd_link;
            steps <= steps + SW'(1);
            state <= S_WALK;
          end
        end
        S_CARVE: begin
          if (grow_fits) begin
            cur   <= tail;
            s     <= CW'(growth);
            lc    <= NO_BLOCK;
            tail  <= AW'(grow_end);
            state <= S_SPLIT;
          end else begin
            res_status <= 1'b1;
            state      <= S_DONE;
          end
        end
        S_SPLIT: begin
          split <= split_ok;
          state <= S_FIX;
        end
        S_FIX: begin
          if (prev == NO_BLOCK) head <= repl;
          res_addr <= FIELD_W'(res_cur);
          state    <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            block_address <= res_addr;
            status        <= res_status;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // re-initialize the pool on a register write
      if (cfg_we) begin
        growth <= cfg_growth;
        head   <= '0;
        tail   <= AW'(HDR_C + CW'(cfg_growth));
      end
    end
  end

  `FFPA_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready,
    "request accepted while a request is in work")
  `FFPA_ASSERT_NOW(a_fail_zero_addr, clk, rst, out_valid && status, block_address == '0,
    "failed allocation reports a nonzero address")
  `FFPA_ASSERT_NOW(a_ptr_range, clk, rst, 1'b1,
    (head <= NO_BLOCK) && (tail <= NO_BLOCK), "list head or arena tail out of range")

endmodule
